@@ sv/lpmd_pkg.sv @@
// lpmd_pkg: shared types and constants for the minimum dot length stretcher
// no dependencies; imported by the serial arithmetic unit and the top level
`default_nettype none

package lpmd_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned MinLenW = 13;
  localparam int unsigned DistW   = 17;
  localparam int unsigned StrokeW = 24;
  localparam int unsigned StepW   = 14;

  localparam logic [MinLenW-1:0] MIN_LEN_RESET = 13'd328;
  localparam logic [StrokeW-1:0] STROKE_MAX    = 24'hFFFFFF;

  // status from the serial unit back to the top level
  typedef struct packed {
    logic               done;
    logic               step_ok;
    logic [DistW-1:0]   seg_len;
    logic [MinLenW-1:0] q_x;
    logic [MinLenW-1:0] q_y;
  } lpmd_res_t;

endpackage

`default_nettype wire

@@ sv/lpmd_if.sv @@
// lpmd_if: valid/ready channel interfaces for points in, points out and config
// no dependencies
`default_nettype none

interface lpmd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic        [7:0]  red_in;
  logic        [7:0]  green_in;
  logic        [7:0]  blue_in;
  logic               frame_end;

  modport source (output valid, pos_x, pos_y, red_in, green_in, blue_in, frame_end,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, red_in, green_in, blue_in, frame_end,
                  output ready);
endinterface

interface lpmd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic        [7:0]  red_out;
  logic        [7:0]  green_out;
  logic        [7:0]  blue_out;

  modport source (output valid, out_x, out_y, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, out_x, out_y, red_out, green_out, blue_out, output ready);
endinterface

interface lpmd_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ sv/lpmd_serial_unit.sv @@
// lpmd_serial_unit: bit-serial squares, square root, products and step divisions
// depends on lpmd_pkg
`default_nettype none

module lpmd_serial_unit
  import lpmd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [CoordW-1:0]  mag_x,
  input  wire logic [CoordW-1:0]  mag_y,
  input  wire logic [MinLenW-1:0] min_len,
  output lpmd_res_t               res
);

  typedef enum logic [2:0] {
    U_IDLE, U_SQR, U_SQRT, U_CHK, U_MUL, U_PREP, U_DIV, U_DONE
  } ustate_t;

  ustate_t      state_r;
  logic [4:0]   cnt_r;
  logic [15:0]  mx_r, my_r, bx_r, by_r;
  logic [33:0]  acc_r;
  logic [18:0]  rem_r;
  logic [16:0]  root_r;
  logic [12:0]  mb_r;
  logic [28:0]  px_r, py_r;
  logic [17:0]  remx_r, remy_r, dvs_r;
  logic [12:0]  qx_r, qy_r;
  logic         ok_r;

  logic [33:0]  sq_nxt;
  logic [20:0]  rem_sh, trial, rem_diff;
  logic         sq_ge;
  logic [18:0]  rem_nxt;
  logic [16:0]  root_nxt;
  logic [28:0]  px_nxt, py_nxt;
  logic [30:0]  nx, ny;
  logic [18:0]  tx, ty, subx, suby;
  logic         gex, gey;
  logic [17:0]  remx_nxt, remy_nxt;

  always_comb begin
    sq_nxt = {acc_r[32:0], 1'b0}
           + {18'd0, (bx_r[15] ? mx_r : 16'd0)}
           + {18'd0, (by_r[15] ? my_r : 16'd0)};

    rem_sh   = {rem_r, acc_r[33:32]};
    trial    = {2'b00, root_r, 2'b01};
    rem_diff = rem_sh - trial;
    sq_ge    = (rem_sh >= trial);
    rem_nxt  = sq_ge ? rem_diff[18:0] : rem_sh[18:0];
    root_nxt = {root_r[15:0], sq_ge};

    px_nxt = {px_r[27:0], 1'b0} + {13'd0, (mb_r[12] ? mx_r : 16'd0)};
    py_nxt = {py_r[27:0], 1'b0} + {13'd0, (mb_r[12] ? my_r : 16'd0)};

    nx = {1'b0, px_r, 1'b0} + {14'd0, root_r};
    ny = {1'b0, py_r, 1'b0} + {14'd0, root_r};

    tx   = {remx_r, qx_r[12]};
    ty   = {remy_r, qy_r[12]};
    subx = tx - {1'b0, dvs_r};
    suby = ty - {1'b0, dvs_r};
    gex  = (tx >= {1'b0, dvs_r});
    gey  = (ty >= {1'b0, dvs_r});
    remx_nxt = gex ? subx[17:0] : tx[17:0];
    remy_nxt = gey ? suby[17:0] : ty[17:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
      ok_r    <= 1'b0;
    end else begin
      case (state_r)
        U_IDLE: begin
          if (start) begin
            mx_r    <= mag_x;
            my_r    <= mag_y;
            bx_r    <= mag_x;
            by_r    <= mag_y;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= U_SQR;
          end
        end
        U_SQR: begin
          acc_r <= sq_nxt;
          bx_r  <= {bx_r[14:0], 1'b0};
          by_r  <= {by_r[14:0], 1'b0};
          if (cnt_r == 5'd15) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            root_r  <= '0;
            state_r <= U_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        U_SQRT: begin
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          acc_r  <= {acc_r[31:0], 2'b00};
          if (cnt_r == 5'd16) begin
            cnt_r   <= '0;
            state_r <= U_CHK;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        U_CHK: begin
          ok_r <= (root_r >= {4'd0, min_len}) && (root_r != '0);
          mb_r <= min_len;
          px_r <= '0;
          py_r <= '0;
          if ((root_r >= {4'd0, min_len}) && (root_r != '0)) begin
            state_r <= U_MUL;
          end else begin
            state_r <= U_DONE;
          end
        end
        U_MUL: begin
          px_r <= px_nxt;
          py_r <= py_nxt;
          mb_r <= {mb_r[11:0], 1'b0};
          if (cnt_r == 5'd12) begin
            cnt_r   <= '0;
            state_r <= U_PREP;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        U_PREP: begin
          remx_r  <= nx[30:13];
          remy_r  <= ny[30:13];
          qx_r    <= nx[12:0];
          qy_r    <= ny[12:0];
          dvs_r   <= {root_r, 1'b0};
          state_r <= U_DIV;
        end
        U_DIV: begin
          remx_r <= remx_nxt;
          remy_r <= remy_nxt;
          qx_r   <= {qx_r[11:0], gex};
          qy_r   <= {qy_r[11:0], gey};
          if (cnt_r == 5'd12) begin
            cnt_r   <= '0;
            state_r <= U_DONE;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        U_DONE: begin
          state_r <= U_IDLE;
        end
        default: begin
          state_r <= U_IDLE;
        end
      endcase
    end
  end

  assign res.done    = (state_r == U_DONE);
  assign res.step_ok = ok_r;
  assign res.seg_len = root_r;
  assign res.q_x     = qx_r;
  assign res.q_y     = qy_r;

endmodule

`default_nettype wire

@@ sv/laser_point_min_dot_length.sv @@
// laser_point_min_dot_length: top level of the minimum dot length stretcher
// depends on lpmd_pkg, lpmd_if and lpmd_serial_unit
//
// in_pt carries one laser point per transfer, out_pt returns one adjusted point
// per input point in the same order, cfg_wr writes min_length (always ready).
// A lit point runs through a bit-serial unit: squaring, square root, one
// check, then multiplying, one setup and dividing when the step vector is
// renewed, plus a finish state; a blank point skips the unit. in_pt is
// ready again in the cycle after the result is registered, so one point is
// in work at a time.
// The result register parts the two channels: a new point is taken while the
// previous result still waits on out_pt. If out_pt stalls, the finished point
// waits in the finish state until the register frees up.
// Reset clears all stroke state and loads min_length with 328.
`default_nettype none

module laser_point_min_dot_length
  import lpmd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  lpmd_in_if.sink     in_pt,
  lpmd_out_if.source  out_pt,
  lpmd_cfg_if.sink    cfg_wr
);

  typedef enum logic [1:0] {T_IDLE, T_CALC, T_FIN} tstate_t;

  tstate_t                   state_r;
  logic [MinLenW-1:0]        min_len_r;

  logic signed [CoordW-1:0]  x_r, y_r;
  logic [ColorW-1:0]         red_r, green_r, blue_r;
  logic                      fend_r, lit_r, negx_r, negy_r;

  logic signed [CoordW-1:0]  prev_x_r, prev_y_r;
  logic [ColorW-1:0]         prev_red_r, prev_green_r, prev_blue_r;
  logic [StrokeW-1:0]        stroke_r;
  logic signed [StepW-1:0]   stepx_r, stepy_r;
  logic                      was_lit_r;

  logic                      out_valid_r;
  logic signed [CoordW-1:0]  out_x_r, out_y_r;
  logic [ColorW-1:0]         out_red_r, out_green_r, out_blue_r;

  lpmd_res_t                 res;
  logic                      in_fire, lit_in, unit_start, fin_go;
  logic [CoordW:0]           dx, dy, ndx, ndy;
  logic [CoordW-1:0]         mag_x, mag_y;

  logic [StrokeW:0]          stroke_sum;
  logic [StrokeW-1:0]        stroke_upd, stroke_aft;
  logic signed [StepW-1:0]   qsx, qsy, step_nx, step_ny, step_ex, step_ey;
  logic                      end_stroke, off, ensure;
  logic [CoordW:0]           sumx, sumy;
  logic signed [CoordW-1:0]  ox, oy;

  lpmd_serial_unit u_serial (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (unit_start),
    .mag_x   (mag_x),
    .mag_y   (mag_y),
    .min_len (min_len_r),
    .res     (res)
  );

  assign in_pt.ready  = (state_r == T_IDLE);
  assign in_fire      = in_pt.valid && in_pt.ready;
  assign lit_in       = |{in_pt.red_in, in_pt.green_in, in_pt.blue_in};
  assign unit_start   = in_fire && lit_in;
  assign fin_go       = (state_r == T_FIN) && (!out_valid_r || out_pt.ready);
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    dx    = {in_pt.pos_x[15], in_pt.pos_x} - {prev_x_r[15], prev_x_r};
    dy    = {in_pt.pos_y[15], in_pt.pos_y} - {prev_y_r[15], prev_y_r};
    ndx   = -dx;
    ndy   = -dy;
    mag_x = dx[CoordW] ? ndx[CoordW-1:0] : dx[CoordW-1:0];
    mag_y = dy[CoordW] ? ndy[CoordW-1:0] : dy[CoordW-1:0];
  end

  always_comb begin
    stroke_sum = {1'b0, stroke_r} + {{(StrokeW-DistW+1){1'b0}}, res.seg_len};
    if (lit_r) begin
      stroke_upd = stroke_sum[StrokeW] ? STROKE_MAX : stroke_sum[StrokeW-1:0];
    end else begin
      stroke_upd = stroke_r;
    end

    qsx = {1'b0, res.q_x};
    qsy = {1'b0, res.q_y};
    if (lit_r && res.step_ok) begin
      step_nx = negx_r ? -qsx : qsx;
      step_ny = negy_r ? -qsy : qsy;
    end else begin
      step_nx = stepx_r;
      step_ny = stepy_r;
    end

    end_stroke = was_lit_r && !lit_r;
    stroke_aft = (!was_lit_r && lit_r) ? '0 : stroke_upd;
    off = (end_stroke && (stroke_upd < {{(StrokeW-MinLenW){1'b0}}, min_len_r}))
       || (fend_r && lit_r && (stroke_aft < {{(StrokeW-MinLenW){1'b0}}, min_len_r}));
    ensure  = off && (step_nx == '0) && (step_ny == '0);
    step_ex = ensure ? {1'b0, min_len_r} : step_nx;
    step_ey = step_ny;

    sumx = {x_r[CoordW-1], x_r} + {{(CoordW-StepW+1){step_ex[StepW-1]}}, step_ex};
    sumy = {y_r[CoordW-1], y_r} + {{(CoordW-StepW+1){step_ey[StepW-1]}}, step_ey};

    if (!off) begin
      ox = x_r;
    end else if (sumx[CoordW] != sumx[CoordW-1]) begin
      ox = sumx[CoordW] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      ox = sumx[CoordW-1:0];
    end

    if (!off) begin
      oy = y_r;
    end else if (sumy[CoordW] != sumy[CoordW-1]) begin
      oy = sumy[CoordW] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      oy = sumy[CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      min_len_r <= cfg_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      out_valid_r  <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_red_r   <= '0;
      prev_green_r <= '0;
      prev_blue_r  <= '0;
      stroke_r     <= '0;
      stepx_r      <= '0;
      stepy_r      <= '0;
      was_lit_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_pt.ready && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (in_fire) begin
            x_r     <= in_pt.pos_x;
            y_r     <= in_pt.pos_y;
            red_r   <= in_pt.red_in;
            green_r <= in_pt.green_in;
            blue_r  <= in_pt.blue_in;
            fend_r  <= in_pt.frame_end;
            lit_r   <= lit_in;
            negx_r  <= dx[CoordW];
            negy_r  <= dy[CoordW];
            state_r <= lit_in ? T_CALC : T_FIN;
          end
        end
        T_CALC: begin
          if (res.done) begin
            state_r <= T_FIN;
          end
        end
        T_FIN: begin
          if (fin_go) begin
            out_valid_r <= 1'b1;
            out_x_r     <= ox;
            out_y_r     <= oy;
            out_red_r   <= end_stroke ? prev_red_r   : red_r;
            out_green_r <= end_stroke ? prev_green_r : green_r;
            out_blue_r  <= end_stroke ? prev_blue_r  : blue_r;
            stroke_r    <= stroke_aft;
            stepx_r     <= step_ex;
            stepy_r     <= step_ey;
            was_lit_r   <= lit_r;
            if (lit_r) begin
              prev_x_r     <= x_r;
              prev_y_r     <= y_r;
              prev_red_r   <= red_r;
              prev_green_r <= green_r;
              prev_blue_r  <= blue_r;
            end
            state_r <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_pt.valid     = out_valid_r;
  assign out_pt.out_x     = out_x_r;
  assign out_pt.out_y     = out_y_r;
  assign out_pt.red_out   = out_red_r;
  assign out_pt.green_out = out_green_r;
  assign out_pt.blue_out  = out_blue_r;

endmodule

`default_nettype wire

@@ tb/laser_point_min_dot_length_tb.sv @@
// laser_point_min_dot_length_tb: self-checking bench for the minimum dot length stretcher
// depends on lpmd_pkg, lpmd_if and the rtl top laser_point_min_dot_length
// drives points and min_length writes, predicts every adjusted point, checks results in order
`default_nettype none

module laser_point_min_dot_length_tb
  import lpmd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 5000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
  } point_t;

  class dot_stretch_scoreboard;
    logic [MinLenW-1:0]  min_len;
    logic signed [15:0]  last_x;
    logic signed [15:0]  last_y;
    logic [7:0]          last_r;
    logic [7:0]          last_g;
    logic [7:0]          last_b;
    logic [StrokeW-1:0]  stroke_len;
    logic signed [15:0]  step_x;
    logic signed [15:0]  step_y;
    bit                  was_lit;
    point_t              expected_q[$];
    int unsigned         fail_count;

    function new();
      min_len    = MIN_LEN_RESET;
      last_x     = '0;
      last_y     = '0;
      last_r     = '0;
      last_g     = '0;
      last_b     = '0;
      stroke_len = '0;
      step_x     = '0;
      step_y     = '0;
      was_lit    = 1'b0;
      fail_count = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag(string what);
      if (fail_count < 10) $display("%s", what);
      fail_count++;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      r = longint'($sqrt(real'(v)));
      while (r * r > v) r = r - 1;
      while ((r + 1) * (r + 1) <= v) r = r + 1;
      return r;
    endfunction

    // component scaled to length min_len, rounded half away from zero
    function logic signed [15:0] scaled(int d, longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q = (mag * min_len * 2 + len) / (2 * len);
      return (d < 0) ? 16'(-int'(q)) : 16'(int'(q));
    endfunction

    function logic signed [15:0] nudge(logic signed [15:0] p, logic signed [15:0] s);
      int v;
      v = int'(p) + int'(s);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
    endfunction

    function void default_step();
      if (step_x == 0 && step_y == 0) step_x = signed'({3'b000, min_len});
    endfunction

    function void note_point(point_t p, bit fend);
      int              dx;
      int              dy;
      longint unsigned d2;
      longint unsigned len;
      longint unsigned total;
      bit              lit;
      point_t          res;
      lit = (p.r | p.g | p.b) != 0;
      res = p;
      if (lit) begin
        dx = int'(p.x) - int'(last_x);
        dy = int'(p.y) - int'(last_y);
        d2 = longint'(dx) * dx + longint'(dy) * dy;
        len = floor_sqrt(d2);
        total = longint'(stroke_len) + len;
        stroke_len = (total > STROKE_MAX) ? STROKE_MAX : total[StrokeW-1:0];
        if (len != 0 && len >= min_len) begin
          step_x = scaled(dx, len);
          step_y = scaled(dy, len);
        end
      end
      if (was_lit && !lit) begin
        res.r = last_r;
        res.g = last_g;
        res.b = last_b;
        if (stroke_len < min_len) begin
          default_step();
          res.x = nudge(res.x, step_x);
          res.y = nudge(res.y, step_y);
        end
      end
      if (!was_lit && lit) stroke_len = '0;
      if (lit) begin
        last_x = p.x;
        last_y = p.y;
        last_r = p.r;
        last_g = p.g;
        last_b = p.b;
      end
      was_lit = lit;
      if (fend && lit && stroke_len < min_len) begin
        default_step();
        res.x = nudge(res.x, step_x);
        res.y = nudge(res.y, step_y);
      end
      expected_q.push_back(res);
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result x=%0d y=%0d rgb=%02h%02h%02h",
                       got.x, got.y, got.r, got.g, got.b));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want)
        flag($sformatf("mismatch: expected x=%0d y=%0d rgb=%02h%02h%02h, got x=%0d y=%0d rgb=%02h%02h%02h",
                       want.x, want.y, want.r, want.g, want.b,
                       got.x, got.y, got.r, got.g, got.b));
    endfunction

    function void flag_leftover();
      if (expected_q.size() != 0)
        flag($sformatf("%0d expected results never arrived", expected_q.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lpmd_in_if  in_pt();
  lpmd_out_if out_pt();
  lpmd_cfg_if cfg_wr();

  dot_stretch_scoreboard sb;

  bit          tx_steady;
  bit          rx_steady;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  laser_point_min_dot_length uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pt  (in_pt),
    .out_pt (out_pt),
    .cfg_wr (cfg_wr)
  );

  always #1ns clk = ~clk;

  // transfer monitor and watchdog
  always @(posedge clk) begin
    point_t seen;
    if (rst_n) begin
      if (out_pt.valid && out_pt.ready) begin
        seen = {out_pt.out_x, out_pt.out_y, out_pt.red_out, out_pt.green_out, out_pt.blue_out};
        sb.check_point(seen);
      end
      if (in_pt.valid && in_pt.ready) begin
        seen = {in_pt.pos_x, in_pt.pos_y, in_pt.red_in, in_pt.green_in, in_pt.blue_in};
        sb.note_point(seen, in_pt.frame_end);
      end
      if (cfg_wr.valid && cfg_wr.ready) sb.min_len = cfg_wr.data;
      if ((out_pt.valid && out_pt.ready) || (in_pt.valid && in_pt.ready) ||
          (cfg_wr.valid && cfg_wr.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // result receiver
  initial begin
    out_pt.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_pt.ready <= 1'b0;
        stall_left--;
      end else if (rx_steady) begin
        out_pt.ready <= 1'b1;
      end else begin
        out_pt.ready <= ($urandom_range(99) >= 19);
      end
    end
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int spread(int a);
    return int'($urandom_range(2 * a)) - a;
  endfunction

  function automatic logic [23:0] lit_colour();
    logic [23:0] c;
    c = 24'($urandom);
    if ($urandom_range(3) == 0) c = c & (24'hFF << (8 * $urandom_range(2)));
    if (c == 0) c[7:0] = 8'($urandom_range(1, 255));
    return c;
  endfunction

  task automatic send_point(int x, int y, logic [23:0] rgb, bit fe);
    while (!tx_steady && $urandom_range(99) < 19) begin
      in_pt.valid <= 1'b0;
      @(posedge clk);
    end
    in_pt.valid     <= 1'b1;
    in_pt.pos_x     <= x[15:0];
    in_pt.pos_y     <= y[15:0];
    in_pt.red_in    <= rgb[23:16];
    in_pt.green_in  <= rgb[15:8];
    in_pt.blue_in   <= rgb[7:0];
    in_pt.frame_end <= fe;
    do @(posedge clk); while (!in_pt.ready);
  endtask

  task automatic drain_results();
    in_pt.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_min_length(logic [MinLenW-1:0] v);
    drain_results();
    cfg_wr.valid <= 1'b1;
    cfg_wr.data  <= v;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
  endtask

  // mostly short strokes around min_length followed by blanks, some raw noise
  task automatic run_points(int unsigned count);
    int unsigned done_n;
    int          px;
    int          py;
    int          mag;
    int          len;
    int          blanks;
    done_n = 0;
    while (done_n < count) begin
      if ($urandom_range(99) < 80) begin
        mag = (sb.min_len < 8) ? 8 : int'(sb.min_len);
        case ($urandom_range(3))
          0: mag = mag / 4 + 1;
          1: mag = mag;
          2: mag = mag * 2;
          default: mag = 65535;
        endcase
        px = int'($urandom_range(65535)) - 32768;
        py = int'($urandom_range(65535)) - 32768;
        if ($urandom_range(9) == 0) px = $urandom_range(1) ? 32767 : -32768;
        if ($urandom_range(9) == 0) py = $urandom_range(1) ? 32767 : -32768;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send_point(px, py, lit_colour(), $urandom_range(9) == 0);
          if ($urandom_range(9) != 0) begin
            px = clamp16(px + spread(mag));
            py = clamp16(py + spread(mag));
          end
        end
        blanks = $urandom_range(1, 3);
        for (int i = 0; i < blanks; i++)
          send_point(clamp16(px + spread(mag)), clamp16(py + spread(mag)), 24'h0,
                     $urandom_range(9) == 0);
        done_n += len + blanks;
      end else begin
        send_point(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                   ($urandom_range(9) < 3) ? 24'h0 : 24'($urandom), $urandom_range(1) == 1);
        done_n++;
      end
    end
  endtask

  initial begin
    sb = new();
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    stall_left   = 0;
    quiet_cycles = 0;
    rst_n           <= 1'b0;
    in_pt.valid     <= 1'b0;
    in_pt.pos_x     <= '0;
    in_pt.pos_y     <= '0;
    in_pt.red_in    <= '0;
    in_pt.green_in  <= '0;
    in_pt.blue_in   <= '0;
    in_pt.frame_end <= 1'b0;
    cfg_wr.valid    <= 1'b0;
    cfg_wr.data     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // frame end on a blank, then a stroke with no movement
    send_point(100, 100, 24'h000000, 1'b1);
    send_point(0, 0, 24'hFF0000, 1'b0);
    send_point(10, 20, 24'h000000, 1'b0);
    // a long diagonal stroke, then a long vertical one, across the full range
    send_point(32767, 32767, 24'h00FF00, 1'b0);
    send_point(32767, -32768, 24'h0000FF, 1'b0);
    send_point(32767, 0, 24'h000000, 1'b0);
    // frame end on a short lit stroke, negative saturation
    send_point(-32768, -32768, 24'hFFFFFF, 1'b1);
    send_point(-32768, 5, 24'h000000, 1'b0);
    // short movement that keeps the step, then a long one
    send_point(100, 100, 24'h010000, 1'b0);
    send_point(150, 100, 24'h000100, 1'b0);
    send_point(32767, 32700, 24'h000001, 1'b1);
    send_point(32767, 32767, 24'h000000, 1'b1);
    // positive saturation on frame end and at stroke end
    send_point(32700, 32767, 24'h000080, 1'b1);
    send_point(32767, 32767, 24'h000000, 1'b0);
    send_point(-1, -1, 24'h808080, 1'b0);
    send_point(-1, -1, 24'h7F7F7F, 1'b0);
    send_point(0, 0, 24'h000000, 1'b1);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        1: write_min_length(13'd1);
        2: write_min_length(13'd8191);
        3: write_min_length(13'd0);
        4: write_min_length(13'($urandom_range(2, 8190)));
        5: write_min_length(13'($urandom_range(2, 8190)));
        6: write_min_length(MIN_LEN_RESET);
        default: ;
      endcase
      tx_steady = (ph == 4);
      rx_steady = (ph == 4);
      run_points(135);
      drain_results();
      if (ph == 1) stall_left = 300;
      run_points(135);
    end

    drain_results();
    repeat (100) @(posedge clk);
    sb.flag_leftover();
    if (sb.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
